>>> hw/rtl/c8_pkg.sv
// Package for the CHIP-8 instruction core: sizes, codes, sequencer states
// and the hex font table loaded by the memory clearing pass.
// No dependencies.
`default_nettype none

package c8_pkg;

  // Sizes of the machine.
  localparam int MEM_BYTES     = 4096;
  localparam int ADDR_W        = 12;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_W         = 5;
  localparam int XPOS_W        = 6;
  localparam int VREG_N        = 16;
  localparam int VIDX_W        = 4;
  localparam int FONT_LEN      = 80;
  localparam int FONT_IDX_W    = 7;

  localparam logic [ADDR_W-1:0] FONT_BASE      = 12'h050;
  localparam logic [ADDR_W-1:0] START_ADDR_RST = 12'h200;
  localparam logic [VIDX_W-1:0] VF_IDX         = 4'hF;

  // Item functions.
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_STEP  = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  // Opcode classes (top nibble) and the clear-screen opcode.
  localparam logic [3:0]  OPC_SYS = 4'h0;
  localparam logic [3:0]  OPC_JP  = 4'h1;
  localparam logic [3:0]  OPC_LD  = 4'h6;
  localparam logic [3:0]  OPC_ADD = 4'h7;
  localparam logic [3:0]  OPC_LDI = 4'hA;
  localparam logic [3:0]  OPC_DRW = 4'hD;
  localparam logic [15:0] OP_CLS  = 16'h00E0;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH_HI,
    S_FETCH_LO,
    S_EXEC,
    S_ADD,
    S_DRAW_X,
    S_DRAW_Y,
    S_DRAW_RD,
    S_DRAW_WR,
    S_ROW,
    S_DONE
  } state_t;

  localparam logic [7:0] FONT_GLYPHS [0:FONT_LEN-1] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Reset contents of main memory: the font at its base, zero elsewhere.
  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] offs;
    offs = addr - FONT_BASE;
    if (addr >= FONT_BASE && offs < ADDR_W'(FONT_LEN)) begin
      return FONT_GLYPHS[offs[FONT_IDX_W-1:0]];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/c8_in_if.sv
// Input channel of the CHIP-8 instruction core: valid/ready and one item.
// Depends on c8_pkg for field widths.
`default_nettype none

interface c8_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [c8_pkg::ADDR_W-1:0]    address;
  logic [7:0]                   data;
  logic [c8_pkg::ROW_W-1:0]     row;

  modport source (output valid, func, address, data, row, input ready);
  modport sink   (input valid, func, address, data, row, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/c8_out_if.sv
// Result channel of the CHIP-8 instruction core: valid/ready and one result.
// Depends on c8_pkg for field widths.
`default_nettype none

interface c8_out_if;
  logic                              valid;
  logic                              ready;
  logic [c8_pkg::ADDR_W-1:0]         next_pc;
  logic [15:0]                       executed_opcode;
  logic                              collision;
  logic [c8_pkg::SCREEN_WIDTH-1:0]   row_pixels;

  modport source (output valid, next_pc, executed_opcode, collision, row_pixels,
                  input ready);
  modport sink   (input valid, next_pc, executed_opcode, collision, row_pixels,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/c8_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/c8_seq.sv
// Sequencer of the CHIP-8 instruction core: fetches, decodes and executes
// by read-modify-write on the three RAMs, and holds the result register.
// Depends on c8_pkg, c8_in_if and c8_out_if.
`default_nettype none

module c8_seq (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  c8_in_if.sink                                      in_if,
  c8_out_if.source                                   out_if,
  // Main memory port.
  output logic                                       main_we,
  output logic [c8_pkg::ADDR_W-1:0]                  main_waddr,
  output logic [7:0]                                 main_wdata,
  output logic [c8_pkg::ADDR_W-1:0]                  main_raddr,
  input  wire logic [7:0]                            main_rdata,
  // Data register file port.
  output logic                                       v_we,
  output logic [c8_pkg::VIDX_W-1:0]                  v_waddr,
  output logic [7:0]                                 v_wdata,
  output logic [c8_pkg::VIDX_W-1:0]                  v_raddr,
  input  wire logic [7:0]                            v_rdata,
  // Display row port.
  output logic                                       d_we,
  output logic [c8_pkg::ROW_W-1:0]                   d_waddr,
  output logic [c8_pkg::SCREEN_WIDTH-1:0]            d_wdata,
  output logic [c8_pkg::ROW_W-1:0]                   d_raddr,
  input  wire logic [c8_pkg::SCREEN_WIDTH-1:0]       d_rdata
);

  c8_pkg::state_t state_r, state_nxt;

  logic [c8_pkg::ADDR_W-1:0]       clr_r;
  logic [c8_pkg::ADDR_W-1:0]       pc_r;
  logic [c8_pkg::ADDR_W-1:0]       idx_r;
  logic                            vf0_r;
  logic [c8_pkg::VREG_N-1:0]       v_vld_r;
  logic [c8_pkg::SCREEN_HEIGHT-1:0] d_vld_r;
  logic                            v_rd_vld_r;
  logic                            d_rd_vld_r;
  logic                            step_r;
  logic                            read_r;
  logic [7:0]                      op_hi_r;
  logic [15:0]                     op_r;
  logic [c8_pkg::XPOS_W-1:0]       x0_r;
  logic [c8_pkg::ROW_W-1:0]        y0_r;
  logic [3:0]                      ri_r;
  logic                            hit_r;
  logic [c8_pkg::SCREEN_WIDTH-1:0] pix_r;

  logic                            out_valid_r;
  logic [c8_pkg::ADDR_W-1:0]       out_pc_r;
  logic [15:0]                     out_op_r;
  logic                            out_col_r;
  logic [c8_pkg::SCREEN_WIDTH-1:0] out_pix_r;

  logic                            in_acc;
  logic                            load_out;
  logic [7:0]                      v_data;
  logic [c8_pkg::SCREEN_WIDTH-1:0] d_data;
  logic [c8_pkg::ROW_W:0]          cur_y;
  logic                            draw_go;
  logic [c8_pkg::SCREEN_WIDTH-1:0] sprite_mask;
  logic [3:0]                      op_x;
  logic [3:0]                      op_y;
  logic [7:0]                      op_nn;

  // Decoded opcode fields.
  assign op_x  = op_r[11:8];
  assign op_y  = op_r[7:4];
  assign op_nn = op_r[7:0];

  // Never-written entries of the register file and display read as zero.
  assign v_data = v_rd_vld_r ? v_rdata : 8'h00;
  assign d_data = d_rd_vld_r ? d_rdata : '0;

  // Draw row position and the sprite row placed at its start column; bits
  // shifted past the right edge fall away, which clips them.
  assign cur_y       = {1'b0, y0_r} + {2'b00, ri_r};
  assign draw_go     = (ri_r < op_r[3:0]) && !cur_y[c8_pkg::ROW_W];
  assign sprite_mask = {main_rdata, {(c8_pkg::SCREEN_WIDTH-8){1'b0}}} >> x0_r;

  assign in_acc = in_if.valid && in_if.ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      c8_pkg::S_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = c8_pkg::S_IDLE;
        end
      end
      c8_pkg::S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.func == c8_pkg::FN_STEP) begin
            state_nxt = c8_pkg::S_FETCH_HI;
          end else if (in_if.func == c8_pkg::FN_READ) begin
            state_nxt = c8_pkg::S_ROW;
          end else begin
            state_nxt = c8_pkg::S_DONE;
          end
        end
      end
      c8_pkg::S_FETCH_HI: state_nxt = c8_pkg::S_FETCH_LO;
      c8_pkg::S_FETCH_LO: state_nxt = c8_pkg::S_EXEC;
      c8_pkg::S_EXEC: begin
        unique case (op_r[15:12])
          c8_pkg::OPC_ADD: state_nxt = c8_pkg::S_ADD;
          c8_pkg::OPC_DRW: state_nxt = c8_pkg::S_DRAW_X;
          default:         state_nxt = c8_pkg::S_DONE;
        endcase
      end
      c8_pkg::S_ADD:     state_nxt = c8_pkg::S_DONE;
      c8_pkg::S_DRAW_X:  state_nxt = c8_pkg::S_DRAW_Y;
      c8_pkg::S_DRAW_Y:  state_nxt = c8_pkg::S_DRAW_RD;
      c8_pkg::S_DRAW_RD: state_nxt = draw_go ? c8_pkg::S_DRAW_WR : c8_pkg::S_DONE;
      c8_pkg::S_DRAW_WR: state_nxt = c8_pkg::S_DRAW_RD;
      c8_pkg::S_ROW:     state_nxt = c8_pkg::S_DONE;
      c8_pkg::S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = c8_pkg::S_IDLE;
        end
      end
      default: state_nxt = c8_pkg::S_IDLE;
    endcase
  end

  // Output logic: handshake and RAM port controls.
  always_comb begin
    in_if.ready = 1'b0;
    load_out    = 1'b0;
    main_we     = 1'b0;
    main_waddr  = in_if.address;
    main_wdata  = in_if.data;
    main_raddr  = pc_r;
    v_we        = 1'b0;
    v_waddr     = op_x;
    v_wdata     = op_nn;
    v_raddr     = op_x;
    d_we        = 1'b0;
    d_waddr     = cur_y[c8_pkg::ROW_W-1:0];
    d_wdata     = d_data ^ sprite_mask;
    d_raddr     = cur_y[c8_pkg::ROW_W-1:0];
    unique case (state_r)
      c8_pkg::S_CLEAR: begin
        main_we    = 1'b1;
        main_waddr = clr_r;
        main_wdata = c8_pkg::font_byte(clr_r);
      end
      c8_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        main_we     = in_if.valid && (in_if.func == c8_pkg::FN_WRITE);
        d_raddr     = in_if.row;
      end
      c8_pkg::S_FETCH_HI: begin
        main_raddr = pc_r + 12'd1;
      end
      c8_pkg::S_EXEC: begin
        v_we = (op_r[15:12] == c8_pkg::OPC_LD);
      end
      c8_pkg::S_ADD: begin
        v_we    = 1'b1;
        v_wdata = v_data + op_nn;
      end
      c8_pkg::S_DRAW_X: begin
        v_raddr = op_y;
      end
      c8_pkg::S_DRAW_RD: begin
        main_raddr = idx_r + {8'h00, ri_r};
        if (!draw_go) begin
          v_we    = 1'b1;
          v_waddr = c8_pkg::VF_IDX;
          v_wdata = {7'h00, hit_r};
        end
      end
      c8_pkg::S_DRAW_WR: begin
        d_we = 1'b1;
      end
      c8_pkg::S_DONE: begin
        load_out = !out_valid_r || out_if.ready;
      end
      default: begin
      end
    endcase
  end

  // State, clearing counter and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c8_pkg::S_CLEAR;
      clr_r   <= '0;
      pc_r    <= c8_pkg::START_ADDR_RST;
      idx_r   <= '0;
      vf0_r   <= 1'b0;
      v_vld_r <= '0;
      d_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == c8_pkg::S_CLEAR) begin
        clr_r <= clr_r + 12'd1;
      end
      if (state_r == c8_pkg::S_FETCH_LO) begin
        pc_r <= pc_r + 12'd2;
      end
      if (state_r == c8_pkg::S_EXEC) begin
        if (op_r[15:12] == c8_pkg::OPC_JP) begin
          pc_r <= op_r[c8_pkg::ADDR_W-1:0];
        end
        if (op_r[15:12] == c8_pkg::OPC_LDI) begin
          idx_r <= op_r[c8_pkg::ADDR_W-1:0];
        end
        if (op_r == c8_pkg::OP_CLS) begin
          d_vld_r <= '0;
        end
      end
      // Keep a copy of the low bit of VF for the collision field.
      if (v_we) begin
        v_vld_r[v_waddr] <= 1'b1;
        if (v_waddr == c8_pkg::VF_IDX) begin
          vf0_r <= v_wdata[0];
        end
      end
      if (d_we) begin
        d_vld_r[d_waddr] <= 1'b1;
      end
    end
  end

  // Valid bits that travel with each register file and display read.
  always_ff @(posedge clk) begin
    v_rd_vld_r <= v_vld_r[v_raddr];
    d_rd_vld_r <= d_vld_r[d_raddr];
  end

  // Item working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      step_r <= (in_if.func == c8_pkg::FN_STEP);
      read_r <= (in_if.func == c8_pkg::FN_READ);
    end
    if (state_r == c8_pkg::S_FETCH_HI) begin
      op_hi_r <= main_rdata;
    end
    if (state_r == c8_pkg::S_FETCH_LO) begin
      op_r <= {op_hi_r, main_rdata};
    end
    if (state_r == c8_pkg::S_DRAW_X) begin
      x0_r <= v_data[c8_pkg::XPOS_W-1:0];
    end
    if (state_r == c8_pkg::S_DRAW_Y) begin
      y0_r  <= v_data[c8_pkg::ROW_W-1:0];
      ri_r  <= '0;
      hit_r <= 1'b0;
    end
    if (state_r == c8_pkg::S_DRAW_WR) begin
      ri_r  <= ri_r + 4'd1;
      hit_r <= hit_r | (|(d_data & sprite_mask));
    end
    if (state_r == c8_pkg::S_ROW) begin
      pix_r <= d_data;
    end
  end

  // Result register: holds a finished beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pc_r  <= pc_r;
      out_op_r  <= step_r ? op_r : 16'h0000;
      out_col_r <= vf0_r;
      out_pix_r <= read_r ? pix_r : '0;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.next_pc         = out_pc_r;
  assign out_if.executed_opcode = out_op_r;
  assign out_if.collision       = out_col_r;
  assign out_if.row_pixels      = out_pix_r;

endmodule

`default_nettype wire

>>> hw/rtl/chip8_instruction_core.sv
// CHIP-8 instruction core (subset): memory load, single step and display read.
// Usage: each beat on in_if carries func (write byte, step, read row) with its
// operands; each accepted beat gives exactly one beat on out_if with the
// program counter, the fetched opcode, VF bit 0 and the requested row.
// A write or an unused func goes straight to the result state; a row read
// first registers the display row; a step fetches the opcode's high and low
// bytes, then executes it, an add in a further state. A draw reads VX and VY,
// then for each of up to 15 sprite rows reads the sprite byte and display row,
// then does the XOR write-back, on the single read port of each memory. One
// item is in work at a time; the next beat is taken once the result sits in
// the output register, so a stalled receiver holds only that register and
// then the input.
// Reset is synchronous and active low. After it the core takes no input
// while it writes the font and zeros through main memory, one byte a cycle;
// the register file and display clear at once via valid bits.
// The configuration register (cfg_we, cfg_wdata) holds the start address,
// 0x200 after reset; writing it leaves the running program counter as it is.
// Depends on c8_pkg, c8_in_if, c8_out_if, c8_ram and c8_seq.
`default_nettype none

module chip8_instruction_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  c8_in_if.sink                          in_if,
  c8_out_if.source                       out_if,
  input  wire logic                      cfg_we,
  input  wire logic [c8_pkg::ADDR_W-1:0] cfg_wdata
);

  logic [c8_pkg::ADDR_W-1:0]        start_addr_r;

  logic                             main_we;
  logic [c8_pkg::ADDR_W-1:0]        main_waddr;
  logic [7:0]                       main_wdata;
  logic [c8_pkg::ADDR_W-1:0]        main_raddr;
  logic [7:0]                       main_rdata;
  logic                             v_we;
  logic [c8_pkg::VIDX_W-1:0]        v_waddr;
  logic [7:0]                       v_wdata;
  logic [c8_pkg::VIDX_W-1:0]        v_raddr;
  logic [7:0]                       v_rdata;
  logic                             d_we;
  logic [c8_pkg::ROW_W-1:0]         d_waddr;
  logic [c8_pkg::SCREEN_WIDTH-1:0]  d_wdata;
  logic [c8_pkg::ROW_W-1:0]         d_raddr;
  logic [c8_pkg::SCREEN_WIDTH-1:0]  d_rdata;

  // Start address register; the program counter resets to START_ADDR_RST, not to it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= c8_pkg::START_ADDR_RST;
    end else if (cfg_we) begin
      start_addr_r <= cfg_wdata;
    end
  end

  // Main memory: program and font bytes.
  c8_ram #(
    .WIDTH (8),
    .DEPTH (c8_pkg::MEM_BYTES)
  ) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  // Data registers V0 to VF.
  c8_ram #(
    .WIDTH (8),
    .DEPTH (c8_pkg::VREG_N)
  ) u_vreg_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Display, one 64-pixel row per entry.
  c8_ram #(
    .WIDTH (c8_pkg::SCREEN_WIDTH),
    .DEPTH (c8_pkg::SCREEN_HEIGHT)
  ) u_disp_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // Sequencer.
  c8_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .main_we    (main_we),
    .main_waddr (main_waddr),
    .main_wdata (main_wdata),
    .main_raddr (main_raddr),
    .main_rdata (main_rdata),
    .v_we       (v_we),
    .v_waddr    (v_waddr),
    .v_wdata    (v_wdata),
    .v_raddr    (v_raddr),
    .v_rdata    (v_rdata),
    .d_we       (d_we),
    .d_waddr    (d_waddr),
    .d_wdata    (d_wdata),
    .d_raddr    (d_raddr),
    .d_rdata    (d_rdata)
  );

endmodule

`default_nettype wire
